>>> src/m3i_pkg.sv
// Shared constants and index tables for the 3x3 adjugate inverse unit.
package m3i_pkg;

    localparam int FRAC_SHIFT = 32;
    localparam int N_ELEM     = 9;
    localparam int N_TRIPLE   = 6;

    typedef logic [3:0] t_idx;

    // Cofactor i is x[CP_A[i]] * x[CP_B[i]] - x[CN_A[i]] * x[CN_B[i]], with the
    // matrix elements numbered row-major from 0 to 8.
    localparam t_idx CP_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam t_idx CP_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam t_idx CN_A [N_ELEM] = '{4'd5, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd1};
    localparam t_idx CN_B [N_ELEM] = '{4'd7, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd3};

    // Determinant triple j reuses a two-element product of cofactor TS_COF[j]
    // (its positive product for the first three, its negative one for the
    // last three) times element TS_Z[j]. The last three are subtracted.
    localparam t_idx TS_COF [N_TRIPLE] = '{4'd8, 4'd2, 4'd5, 4'd2, 4'd8, 4'd5};
    localparam t_idx TS_Z   [N_TRIPLE] = '{4'd8, 4'd6, 4'd7, 4'd6, 4'd8, 4'd7};

endpackage

>>> src/m3i_if.sv
// Valid/ready channel interfaces for matrix items and inverse items.
interface m3i_in_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_r0c0;
    logic signed [W-1:0] in_r0c1;
    logic signed [W-1:0] in_r0c2;
    logic signed [W-1:0] in_r1c0;
    logic signed [W-1:0] in_r1c1;
    logic signed [W-1:0] in_r1c2;
    logic signed [W-1:0] in_r2c0;
    logic signed [W-1:0] in_r2c1;
    logic signed [W-1:0] in_r2c2;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
               in_r2c0, in_r2c1, in_r2c2,
        output ready
    );
endinterface

interface m3i_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] inv_r0c0;
    logic signed [W-1:0] inv_r0c1;
    logic signed [W-1:0] inv_r0c2;
    logic signed [W-1:0] inv_r1c0;
    logic signed [W-1:0] inv_r1c1;
    logic signed [W-1:0] inv_r1c2;
    logic signed [W-1:0] inv_r2c0;
    logic signed [W-1:0] inv_r2c1;
    logic signed [W-1:0] inv_r2c2;
    logic                singular;
    logic                saturated;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        output ready
    );
endinterface

>>> src/matrix3_inverse_adjugate_unit.sv
// Pipelined 3x3 matrix inverse by adjugate over determinant, Q8.16 in, Q16.16 out.
//
//   Channel | Dir | Payload                                    | Handshake
//   i_in    | in  | nine Q8.16 elements in_r0c0 .. in_r2c2     | valid/ready
//   o_out   | out | nine Q16.16 elements, singular, saturated  | valid/ready
//
// One item enters per clock unless a stall at the output holds off the input.
// The quotients come from a restoring divider unrolled into OUT_WIDTH stages,
// one quotient bit per stage for all nine elements, which sets the depth.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage loads when it is empty or the stage after it is loading, so a
// stall at the output fills bubbles before the input is held off.
module matrix3_inverse_adjugate_unit
    import m3i_pkg::*;
#(
    parameter int IN_WIDTH  = 24,
    parameter int OUT_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    m3i_in_if.sink       i_in,
    m3i_out_if.source    o_out
);

    localparam int W   = IN_WIDTH;
    localparam int OW  = OUT_WIDTH;
    localparam int PW  = 2 * W;
    localparam int CFW = 2 * W + 1;
    localparam int MLW = 2 * W + 1;
    localparam int TW  = 3 * W;
    localparam int SW  = 3 * W + 2;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = 2 * W + FRAC_SHIFT;
    localparam int CW  = ((NW > DW + OW) ? NW : DW + OW) + 1;
    localparam int NS  = OW + 8;
    localparam int OUT_ST = NS - 1;

    localparam logic [OW-1:0] LIM  = {1'b1, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] MAXV = {1'b0, {(OW-1){1'b1}}};

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [W-1:0] x [N_ELEM];

    logic signed [PW-1:0]  r1_pp [N_ELEM];
    logic signed [PW-1:0]  r1_pn [N_ELEM];
    logic signed [W-1:0]   r1_x  [N_ELEM];

    logic signed [CFW-1:0] r2_cof [N_ELEM];
    logic signed [PW-1:0]  r2_mh  [N_TRIPLE];
    logic signed [MLW-1:0] r2_ml  [N_TRIPLE];

    logic [CFW-1:0]        r3_cm [N_ELEM];
    logic [N_ELEM-1:0]     r3_cn;
    logic signed [TW-1:0]  r3_t  [N_TRIPLE];

    logic [CFW-1:0]        r4_cm [N_ELEM];
    logic [N_ELEM-1:0]     r4_cn;
    logic signed [SW-1:0]  r4_sp;
    logic signed [SW-1:0]  r4_sn;

    logic [CFW-1:0]        r5_cm [N_ELEM];
    logic [N_ELEM-1:0]     r5_cn;
    logic signed [DW-1:0]  r5_det;

    logic [CW-1:0]         r6_num [N_ELEM];
    logic [N_ELEM-1:0]     r6_cn;
    logic [DW-1:0]         r6_dmag;
    logic                  r6_dneg;
    logic                  r6_dz;

    // Divider: index 0 holds the range check, index j has j quotient bits done.
    logic [CW-1:0]         r_rem [OW+1][N_ELEM];
    logic [CW-1:0]         n_rem [OW+1][N_ELEM];
    logic [OW-1:0]         r_q   [OW+1][N_ELEM];
    logic [OW-1:0]         n_q   [OW+1][N_ELEM];
    logic [N_ELEM-1:0]     r_ng  [OW+1];
    logic [N_ELEM-1:0]     n_ng  [OW+1];
    logic [N_ELEM-1:0]     r_ov  [OW+1];
    logic [N_ELEM-1:0]     n_ov  [OW+1];
    logic [DW-1:0]         r_dm  [OW+1];
    logic                  r_dz  [OW+1];

    logic signed [OW-1:0]  r_inv [N_ELEM];
    logic signed [OW-1:0]  n_inv [N_ELEM];
    logic                  r_sing;
    logic                  r_sat;
    logic                  n_sat;

    assign x[0] = i_in.in_r0c0;
    assign x[1] = i_in.in_r0c1;
    assign x[2] = i_in.in_r0c2;
    assign x[3] = i_in.in_r1c0;
    assign x[4] = i_in.in_r1c1;
    assign x[5] = i_in.in_r1c2;
    assign x[6] = i_in.in_r2c0;
    assign x[7] = i_in.in_r2c1;
    assign x[8] = i_in.in_r2c2;

    always_comb begin
        en[OUT_ST] = !r_vld[OUT_ST] || o_out.ready;
        for (int k = OUT_ST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Front stages: products, cofactors and split triple products, triples,
    // partial sums, determinant, magnitudes.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r1_pp[i] <= x[CP_A[i]] * x[CP_B[i]];
                r1_pn[i] <= x[CN_A[i]] * x[CN_B[i]];
                r1_x[i]  <= x[i];
            end
        end
        if (en[1]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r2_cof[i] <= CFW'(r1_pp[i]) - CFW'(r1_pn[i]);
            end
            for (int j = 0; j < N_TRIPLE; j++) begin
                // The two-element product is split into a signed high half
                // and an unsigned low half so that each multiply stays narrow.
                if (j < 3) begin
                    r2_mh[j] <= $signed(r1_pp[TS_COF[j]][PW-1:W]) * r1_x[TS_Z[j]];
                    r2_ml[j] <= $signed({1'b0, r1_pp[TS_COF[j]][W-1:0]}) * r1_x[TS_Z[j]];
                end else begin
                    r2_mh[j] <= $signed(r1_pn[TS_COF[j]][PW-1:W]) * r1_x[TS_Z[j]];
                    r2_ml[j] <= $signed({1'b0, r1_pn[TS_COF[j]][W-1:0]}) * r1_x[TS_Z[j]];
                end
            end
        end
        if (en[2]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r3_cn[i] <= r2_cof[i][CFW-1];
                r3_cm[i] <= r2_cof[i][CFW-1] ? CFW'(-r2_cof[i]) : CFW'(r2_cof[i]);
            end
            for (int j = 0; j < N_TRIPLE; j++) begin
                r3_t[j] <= (TW'(r2_mh[j]) <<< W) + TW'(r2_ml[j]);
            end
        end
        if (en[3]) begin
            r4_cm <= r3_cm;
            r4_cn <= r3_cn;
            r4_sp <= SW'(r3_t[0]) + SW'(r3_t[1]) + SW'(r3_t[2]);
            r4_sn <= SW'(r3_t[3]) + SW'(r3_t[4]) + SW'(r3_t[5]);
        end
        if (en[4]) begin
            r5_cm  <= r4_cm;
            r5_cn  <= r4_cn;
            r5_det <= DW'(r4_sp) - DW'(r4_sn);
        end
        if (en[5]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r6_num[i] <= CW'(r5_cm[i]) << FRAC_SHIFT;
            end
            r6_cn   <= r5_cn;
            r6_dneg <= r5_det[DW-1];
            r6_dmag <= r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
            r6_dz   <= (r5_det == '0);
        end
    end

    // Range check and one restoring-division step per stage.
    always_comb begin
        logic [CW-1:0] sh;
        for (int i = 0; i < N_ELEM; i++) begin
            n_rem[0][i] = r6_num[i];
            n_q[0][i]   = '0;
            n_ov[0][i]  = (r6_num[i] >= (CW'(r6_dmag) << OW));
            n_ng[0][i]  = r6_cn[i] ^ r6_dneg;
        end
        for (int j = 1; j <= OW; j++) begin
            for (int i = 0; i < N_ELEM; i++) begin
                sh = CW'(r_dm[j-1]) << (OW - j);
                n_ng[j][i] = r_ng[j-1][i];
                n_ov[j][i] = r_ov[j-1][i];
                if (r_rem[j-1][i] >= sh) begin
                    n_rem[j][i] = r_rem[j-1][i] - sh;
                    n_q[j][i]   = r_q[j-1][i] | (OW'(1) << (OW - j));
                end else begin
                    n_rem[j][i] = r_rem[j-1][i];
                    n_q[j][i]   = r_q[j-1][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_ov[0]  <= n_ov[0];
            r_ng[0]  <= n_ng[0];
            r_dm[0]  <= r6_dmag;
            r_dz[0]  <= r6_dz;
        end
        for (int j = 1; j <= OW; j++) begin
            if (en[6+j]) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_ov[j]  <= n_ov[j];
                r_ng[j]  <= n_ng[j];
                r_dm[j]  <= r_dm[j-1];
                r_dz[j]  <= r_dz[j-1];
            end
        end
    end

    // Sign and saturation; a zero determinant forces zeros.
    always_comb begin
        logic [OW-1:0] q;
        n_sat = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            q = r_q[OW][i];
            if (r_dz[OW]) begin
                n_inv[i] = '0;
            end else if (r_ov[OW][i]) begin
                n_inv[i] = r_ng[OW][i] ? LIM : MAXV;
                n_sat    = 1'b1;
            end else if (r_ng[OW][i]) begin
                if (q > LIM) begin
                    n_inv[i] = LIM;
                    n_sat    = 1'b1;
                end else begin
                    n_inv[i] = -q;
                end
            end else begin
                if (q > MAXV) begin
                    n_inv[i] = MAXV;
                    n_sat    = 1'b1;
                end else begin
                    n_inv[i] = q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[OUT_ST]) begin
            r_inv  <= n_inv;
            r_sing <= r_dz[OW];
            r_sat  <= n_sat;
        end
    end

    assign o_out.valid     = r_vld[OUT_ST];
    assign o_out.inv_r0c0  = r_inv[0];
    assign o_out.inv_r0c1  = r_inv[1];
    assign o_out.inv_r0c2  = r_inv[2];
    assign o_out.inv_r1c0  = r_inv[3];
    assign o_out.inv_r1c1  = r_inv[4];
    assign o_out.inv_r1c2  = r_inv[5];
    assign o_out.inv_r2c0  = r_inv[6];
    assign o_out.inv_r2c1  = r_inv[7];
    assign o_out.inv_r2c2  = r_inv[8];
    assign o_out.singular  = r_sing;
    assign o_out.saturated = r_sat;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[OUT_ST] && !o_out.ready |=> r_vld[OUT_ST])
        else $error("waiting result was lost");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.singular |-> !o_out.saturated && r_inv[0] == '0
            && r_inv[4] == '0 && r_inv[8] == '0)
        else $error("singular result carries nonzero data or saturation");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && en[6] |=> r_vld[6])
        else $error("item lost between front stages and divider");

endmodule

>>> dv/tb_matrix3_inverse_adjugate_unit.sv
// Testbench for the 3x3 adjugate inverse unit: random and directed matrices checked item by item.
`timescale 1ns / 100ps

typedef struct {
    logic signed [31:0] elem [9];
    logic               singular;
    logic               saturated;
} t_inverse;

class inverse_scoreboard;
    t_inverse pending_inverses[$];
    int       n_errors;
    int       n_checked;
    int       n_singular;
    int       n_saturated;

    // Exact inverse of one matrix, elements given row-major as Q8.16.
    function automatic t_inverse compute_inverse(logic signed [23:0] m [9]);
        t_inverse                  r;
        logic signed [63:0]        x [9];
        logic signed [63:0]        cof [9];
        logic signed [127:0]       det;
        logic [127:0]              dmag;
        logic [127:0]              num;
        logic [127:0]              q;
        logic [63:0]               cmag;
        logic                      neg;
        for (int i = 0; i < 9; i++) x[i] = 64'(m[i]);
        cof[0] = x[4] * x[8] - x[5] * x[7];
        cof[1] = x[2] * x[7] - x[1] * x[8];
        cof[2] = x[1] * x[5] - x[4] * x[2];
        cof[3] = x[6] * x[5] - x[3] * x[8];
        cof[4] = x[0] * x[8] - x[6] * x[2];
        cof[5] = x[3] * x[2] - x[0] * x[5];
        cof[6] = x[3] * x[7] - x[6] * x[4];
        cof[7] = x[6] * x[1] - x[0] * x[7];
        cof[8] = x[0] * x[4] - x[1] * x[3];
        det = 128'(x[0]) * 128'(cof[0]) + 128'(x[1]) * 128'(cof[3])
            + 128'(x[2]) * 128'(cof[6]);
        r.saturated = 1'b0;
        r.singular  = (det == 0);
        if (r.singular) begin
            for (int i = 0; i < 9; i++) r.elem[i] = '0;
            return r;
        end
        dmag = det[127] ? -det : det;
        for (int i = 0; i < 9; i++) begin
            cmag = cof[i][63] ? -cof[i] : cof[i];
            num  = {32'd0, cmag, 32'd0};
            q    = num / dmag;
            neg  = (cof[i][63] != det[127]) && (q != 0);
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    r.elem[i] = 32'sh8000_0000;
                    r.saturated = 1'b1;
                end else begin
                    r.elem[i] = -q[31:0];
                end
            end else begin
                if (q > 128'h7fff_ffff) begin
                    r.elem[i] = 32'sh7fff_ffff;
                    r.saturated = 1'b1;
                end else begin
                    r.elem[i] = q[31:0];
                end
            end
        end
        return r;
    endfunction

    function void note_matrix(logic signed [23:0] m [9]);
        pending_inverses.push_back(compute_inverse(m));
    endfunction

    function void report_mismatch(string what, longint got, longint want);
        $display("MISMATCH item %0d %s: got %0d expected %0d", n_checked, what, got, want);
        n_errors++;
    endfunction

    function void check_inverse(t_inverse got);
        t_inverse want;
        if (pending_inverses.size() == 0) begin
            $display("MISMATCH unexpected result item %0d", n_checked);
            n_errors++;
            return;
        end
        want = pending_inverses.pop_front();
        for (int i = 0; i < 9; i++)
            if (got.elem[i] !== want.elem[i])
                report_mismatch($sformatf("element %0d", i), got.elem[i], want.elem[i]);
        if (got.singular !== want.singular)
            report_mismatch("singular", got.singular, want.singular);
        if (got.saturated !== want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
        n_singular  += want.singular;
        n_saturated += want.saturated;
        n_checked++;
    endfunction
endclass

module tb_matrix3_inverse_adjugate_unit;
    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   send_idle_pct = 35;
    int   recv_idle_pct = 51;

    m3i_in_if  #(.W(24)) in_ch ();
    m3i_out_if #(.W(32)) out_ch ();

    matrix3_inverse_adjugate_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    inverse_scoreboard board = new();

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.in_r0c0, in_ch.in_r0c1, in_ch.in_r0c2, in_ch.in_r1c0, in_ch.in_r1c1,
         in_ch.in_r1c2, in_ch.in_r2c0, in_ch.in_r2c1, in_ch.in_r2c2} = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, results checked on handshake.
    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.elem = '{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
                         out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
                         out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2};
            got.singular  = out_ch.singular;
            got.saturated = out_ch.saturated;
            board.check_inverse(got);
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after an accepted item; the next call or the caller drops it.
    task automatic send_matrix(logic signed [23:0] m [9]);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_r0c0 <= m[0]; in_ch.in_r0c1 <= m[1]; in_ch.in_r0c2 <= m[2];
        in_ch.in_r1c0 <= m[3]; in_ch.in_r1c1 <= m[4]; in_ch.in_r1c2 <= m[5];
        in_ch.in_r2c0 <= m[6]; in_ch.in_r2c1 <= m[7]; in_ch.in_r2c2 <= m[8];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_matrix(m);
    endtask

    function automatic logic signed [23:0] random_element(int style);
        case (style)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(131072)) - 65536);
            2: return 24'($signed($urandom_range(512)) - 256);
            default: return ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    task automatic send_random;
        logic signed [23:0] m [9];
        int style;
        int pick;
        style = $urandom_range(3);
        for (int i = 0; i < 9; i++)
            m[i] = ($urandom_range(9) == 0) ? random_element($urandom_range(3))
                                            : random_element(style);
        pick = $urandom_range(19);
        // Near-singular and singular shapes: repeated or scaled rows, a nearly repeated row, or a small diagonal.
        if (pick == 0) begin
            m[3] = m[0]; m[4] = m[1]; m[5] = m[2];
        end else if (pick == 1) begin
            for (int i = 0; i < 3; i++) m[6 + i] = -m[i];
        end else if (pick == 2) begin
            m[0] = m[3] + 24'sd1;
            m[1] = m[4]; m[2] = m[5];
        end else if (pick == 3) begin
            for (int i = 0; i < 9; i++) m[i] = '0;
            m[0] = random_element(2); m[4] = random_element(2); m[8] = random_element(2);
        end
        send_matrix(m);
    endtask

    task automatic wait_drained;
        while (board.pending_inverses.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [23:0] m [9];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, scaled identity, zero, extremes, singular, saturation.
        m = '{24'sh010000, 0, 0, 0, 24'sh010000, 0, 0, 0, 24'sh010000};
        send_matrix(m);
        m = '{24'sh020000, 0, 0, 0, -24'sh040000, 0, 0, 0, 24'sh008000};
        send_matrix(m);
        m = '{default: 24'sd0};
        send_matrix(m);
        m = '{default: 24'sh7fffff};
        send_matrix(m);
        m = '{24'sh7fffff, 0, 0, 0, 24'sh7fffff, 0, 0, 0, 24'sh7fffff};
        send_matrix(m);
        m = '{24'sh800000, 0, 0, 0, 24'sh800000, 0, 0, 0, 24'sh800000};
        send_matrix(m);
        m = '{24'sd1, 0, 0, 0, 24'sd1, 0, 0, 0, 24'sd1};
        send_matrix(m);
        m = '{-24'sd1, 0, 0, 0, 24'sd1, 0, 0, 0, 24'sd1};
        send_matrix(m);
        m = '{24'sh800000, 24'sh7fffff, 24'sd1, 24'sh7fffff, 24'sh800000, -24'sd1,
              24'sd1, -24'sd1, 24'sh800000};
        send_matrix(m);
        m = '{24'sh010000, 24'sh020000, 24'sh030000, 24'sh040000, 24'sh050000,
              24'sh060000, 24'sh070000, 24'sh080000, 24'sh090000};
        send_matrix(m);
        m = '{0, 24'sh010000, 0, 0, 0, 24'sh010000, 24'sh010000, 0, 0};
        send_matrix(m);
        m = '{24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555,
              24'shaaaaaa, 24'sh2aaaaa, 24'sh555555, 24'shd55555};
        send_matrix(m);

        for (int n = 0; n < 650; n++) send_random();
        in_ch.valid <= 1'b0;
        // Pause the sender until the pipeline has drained completely.
        wait_drained();
        send_idle_pct = 51;
        recv_idle_pct = 35;
        for (int n = 0; n < 650; n++) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 640; n++) send_random();
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d inverses, %0d singular, %0d saturated, under varied back-pressure.",
                 board.n_checked, board.n_singular, board.n_saturated);
        if (board.n_errors == 0 && board.pending_inverses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
